FILE: rtl/pdrc_pkg.sv
package pdrc_pkg;

	// Field widths
	localparam int OP_W       = 3;
	localparam int DUTY_W     = 8;
	localparam int STEP_W     = 7;
	localparam int IVL_W      = 6;
	localparam int BITS_W     = 5;
	localparam int CMP_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// Command codes
	typedef enum logic [OP_W-1:0] {
		OP_TICK    = 3'd0,
		OP_SET     = 3'd1,
		OP_RAMP    = 3'd2,
		OP_READY   = 3'd3,
		OP_STANDBY = 3'd4
	} opcode_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PWM_BITS   = 1'b0,
		REG_READY_DUTY = 1'b1
	} cfg_reg_t;

	// Limits and reset values
	localparam logic [STEP_W-1:0] STEP_MAX    = 7'd64;
	localparam logic [STEP_W-1:0] STEP_RESET  = 7'd4;
	localparam logic [IVL_W-1:0]  IVL_MAX     = 6'd50;
	localparam logic [IVL_W-1:0]  IVL_RESET   = 6'd10;
	localparam logic [BITS_W-1:0] BITS_RESET  = 5'd8;
	localparam logic [DUTY_W-1:0] READY_RESET = 8'd255;

	// Outcome of one command word
	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              wrote;
		logic              ramp;
	} upd_t;

endpackage

FILE: rtl/pdrc_if.sv
interface pdrc_cmd_if import pdrc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [DUTY_W-1:0] duty;
	logic [STEP_W-1:0] ramp_step;
	logic [IVL_W-1:0]  interval;

	modport source (output valid, opcode, duty, ramp_step, interval, input ready);
	modport sink (input valid, opcode, duty, ramp_step, interval, output ready);
endinterface

interface pdrc_res_if import pdrc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty_level;
	logic [CMP_W-1:0]  pwm_compare;
	logic              pwm_write;
	logic              ramp_running;

	modport source (output valid, duty_level, pwm_compare, pwm_write, ramp_running,
		input ready);
	modport sink (input valid, duty_level, pwm_compare, pwm_write, ramp_running,
		output ready);
endinterface

FILE: rtl/pwm_duty_ramp_controller_unit.sv
// A result word is valid once its accepted command word has passed stages s1, s2 and s3.
// Throughput: one command word per cycle; the three stages advance together and
// hold while the result word waits, so cmd.ready follows the output register.
// The duty scaling takes one shift-subtract stage and one reciprocal multiply stage.
// Reset (arst_n low): duty, target, countdown and ramp clear, step 4, interval 10,
// pwm_bits 8, ready_duty 255, all stages empty.
module pwm_duty_ramp_controller_unit import pdrc_pkg::*; #(
	parameter int MAX_PWM_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pdrc_cmd_if.sink              cmd,
	pdrc_res_if.source            res
);

	localparam int XW = DUTY_W + MAX_PWM_BITS;

	logic [BITS_W-1:0] pwm_bits_q, eff_bits;
	logic [DUTY_W-1:0] ready_duty_q;
	logic              adv, accept;
	upd_t              upd;

	logic              v_s1, v_s2, v_s3;
	upd_t              u_s1, u_s2, u_s3;
	logic [CMP_W-1:0]  cmp_s3;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_bits_q   <= BITS_RESET;
			ready_duty_q <= READY_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PWM_BITS:   pwm_bits_q   <= cfg_data[BITS_W-1:0];
				REG_READY_DUTY: ready_duty_q <= cfg_data[DUTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp resolution to the supported range
	always_comb begin
		if (pwm_bits_q == '0) begin
			eff_bits = BITS_W'(1);
		end else if (pwm_bits_q > BITS_W'(MAX_PWM_BITS)) begin
			eff_bits = BITS_W'(MAX_PWM_BITS);
		end else begin
			eff_bits = pwm_bits_q;
		end
	end

	// Advance all stages unless the result word is held
	assign adv       = !v_s3 || res.ready;
	assign cmd.ready = adv;
	assign accept    = cmd.valid && adv;

	pdrc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (accept),
		.opcode     (cmd.opcode),
		.duty       (cmd.duty),
		.ramp_step  (cmd.ramp_step),
		.interval   (cmd.interval),
		.ready_duty (ready_duty_q),
		.upd        (upd)
	);

	pdrc_scale #(
		.XW (XW)
	) u_scale (
		.clk     (clk),
		.en      (adv),
		.duty_s1 (u_s1.duty),
		.bits    (eff_bits),
		.cmp_s3  (cmp_s3)
	);

	// Valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Payload of the pipeline
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1 <= upd;
			u_s2 <= u_s1;
			u_s3 <= u_s2;
		end
	end

	assign res.valid        = v_s3;
	assign res.duty_level   = u_s3.duty;
	assign res.pwm_compare  = cmp_s3;
	assign res.pwm_write    = u_s3.wrote;
	assign res.ramp_running = u_s3.ramp;

endmodule

FILE: rtl/pdrc_core.sv
module pdrc_core import pdrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [OP_W-1:0]   opcode,
	input  logic [DUTY_W-1:0] duty,
	input  logic [STEP_W-1:0] ramp_step,
	input  logic [IVL_W-1:0]  interval,
	input  logic [DUTY_W-1:0] ready_duty,
	output upd_t              upd
);

	logic [DUTY_W-1:0] cur_q, tgt_q;
	logic [STEP_W-1:0] step_q;
	logic [IVL_W-1:0]  ivl_q, cnt_q;
	logic              ramp_q;

	logic [DUTY_W-1:0] cur_d, tgt_d, move;
	logic [STEP_W-1:0] step_d;
	logic [IVL_W-1:0]  ivl_d, cnt_d, reload;
	logic              ramp_d;
	logic [DUTY_W:0]   up_sum, down_lim;

	// Next duty for one ramp move, saturating at the target
	always_comb begin
		up_sum   = {1'b0, cur_q} + {2'b0, step_q};
		down_lim = {1'b0, tgt_q} + {2'b0, step_q};
		if (cur_q < tgt_q) begin
			move = (up_sum > {1'b0, tgt_q}) ? tgt_q : up_sum[DUTY_W-1:0];
		end else begin
			move = ({1'b0, cur_q} >= down_lim) ? (cur_q - {1'b0, step_q}) : tgt_q;
		end
		reload = (ivl_q != '0) ? (ivl_q - 1'b1) : '0;
	end

	// Decode the command word
	always_comb begin
		cur_d  = cur_q;
		tgt_d  = tgt_q;
		step_d = step_q;
		ivl_d  = ivl_q;
		cnt_d  = cnt_q;
		ramp_d = ramp_q;
		case (opcode_t'(opcode))
			OP_TICK: begin
				if (ramp_q) begin
					if (cnt_q != '0) begin
						cnt_d = cnt_q - 1'b1;
					end else if (cur_q == tgt_q) begin
						ramp_d = 1'b0;
					end else begin
						cur_d = move;
						cnt_d = reload;
					end
				end
			end
			OP_SET: begin
				cur_d = duty;
			end
			OP_RAMP: begin
				if (ramp_step != '0) begin
					step_d = (ramp_step > STEP_MAX) ? STEP_MAX : ramp_step;
				end
				if (interval != '0) begin
					ivl_d = (interval > IVL_MAX) ? IVL_MAX : interval;
				end
				tgt_d  = duty;
				ramp_d = 1'b1;
				cnt_d  = '0;
			end
			OP_READY: begin
				tgt_d  = ready_duty;
				ramp_d = 1'b1;
				cnt_d  = '0;
			end
			OP_STANDBY: begin
				tgt_d  = '0;
				ramp_d = 1'b1;
				cnt_d  = '0;
			end
			default: begin
			end
		endcase
	end

	assign upd.duty  = cur_d;
	assign upd.wrote = (cur_d != cur_q);
	assign upd.ramp  = ramp_d;

	// Commit the update on an accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			tgt_q  <= '0;
			step_q <= STEP_RESET;
			ivl_q  <= IVL_RESET;
			cnt_q  <= '0;
			ramp_q <= 1'b0;
		end else if (en) begin
			cur_q  <= cur_d;
			tgt_q  <= tgt_d;
			step_q <= step_d;
			ivl_q  <= ivl_d;
			cnt_q  <= cnt_d;
			ramp_q <= ramp_d;
		end
	end

endmodule

FILE: rtl/pdrc_scale.sv
module pdrc_scale import pdrc_pkg::*; #(
	parameter int XW = 24
) (
	input  logic              clk,
	input  logic              en,
	input  logic [DUTY_W-1:0] duty_s1,
	input  logic [BITS_W-1:0] bits,
	output logic [CMP_W-1:0]  cmp_s3
);

	// x / 255 as (x * RECIP) >> K, exact for every x below 2^XW
	localparam int          K     = XW + 8;
	localparam int          MW    = XW + 1;
	localparam logic [63:0] RECIP = ((64'd1 << K) + 64'd254) / 64'd255;

	logic [XW-1:0]    dext;
	logic [XW-1:0]    x_s2;
	logic [XW+MW-1:0] prod;

	// Duty times full scale: shift and subtract
	assign dext = XW'(duty_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= (dext << bits) - dext;
		end
	end

	// Divide by 255 through the reciprocal, keep the low compare bits
	assign prod = XW'(x_s2) * MW'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			cmp_s3 <= prod[K +: CMP_W];
		end
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import pdrc_pkg::*;

	localparam int PWM_BITS_CAP = 16;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam int LIMIT_CYCLES = 1000000;

	// Opcodes the block must ignore
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [DUTY_W-1:0] duty;
		logic [STEP_W-1:0] ramp_step;
		logic [IVL_W-1:0]  interval;
	} cmd_word_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_level;
		logic [CMP_W-1:0]  pwm_compare;
		logic              pwm_write;
		logic              ramp_running;
	} res_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pdrc_cmd_if cmd_ch ();
	pdrc_res_if res_ch ();

	pwm_duty_ramp_controller_unit #(
		.MAX_PWM_BITS(PWM_BITS_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	// Shadow of the block: configuration and ramp state
	logic [BITS_W-1:0] sh_pwm_bits;
	logic [DUTY_W-1:0] sh_ready_duty;
	logic [DUTY_W-1:0] sh_duty;
	logic [DUTY_W-1:0] sh_target;
	logic [STEP_W-1:0] sh_step;
	logic [IVL_W-1:0]  sh_interval;
	logic [IVL_W-1:0]  sh_countdown;
	logic              sh_ramp;

	cmd_word_t cmd_backlog[$];
	res_word_t duty_results_due[$];
	cmd_word_t word_on_bus;
	bit        word_offered;
	int        src_gap;
	int        snk_stall;
	int        hold_left;
	bit        hold_req;
	bit        src_calm;
	bit        snk_calm;
	bit        rdy_next;
	int        errors;
	int        cycles;

	// Scale a duty to the PWM full scale under the present resolution
	function automatic logic [CMP_W-1:0] compare_of(input logic [DUTY_W-1:0] d);
		int bits;
		longint unsigned full;
		longint unsigned prod;
		bits = int'(sh_pwm_bits);
		if (bits < 1) bits = 1;
		if (bits > PWM_BITS_CAP) bits = PWM_BITS_CAP;
		full = (64'd1 << bits) - 64'd1;
		prod = (longint'(d) * full) / 64'd255;
		return prod[CMP_W-1:0];
	endfunction

	// Apply one command word to the shadow state and return the result it yields
	function automatic res_word_t advance_duty(input cmd_word_t w);
		res_word_t r;
		int nxt;
		logic wrote;
		wrote = 1'b0;
		case (w.opcode)
			OP_TICK: begin
				if (sh_ramp) begin
					if (sh_countdown != 0) begin
						sh_countdown = sh_countdown - 1'b1;
					end else if (sh_duty == sh_target) begin
						sh_ramp = 1'b0;
					end else begin
						if (sh_duty < sh_target) begin
							nxt = int'(sh_duty) + int'(sh_step);
							if (nxt > int'(sh_target)) nxt = int'(sh_target);
						end else begin
							nxt = (int'(sh_duty) >= int'(sh_target) + int'(sh_step)) ?
								int'(sh_duty) - int'(sh_step) : int'(sh_target);
						end
						wrote = (nxt[DUTY_W-1:0] != sh_duty);
						sh_duty = nxt[DUTY_W-1:0];
						sh_countdown = (sh_interval != 0) ? sh_interval - 1'b1 : '0;
					end
				end
			end
			OP_SET: begin
				wrote = (w.duty != sh_duty);
				sh_duty = w.duty;
			end
			OP_RAMP: begin
				if (w.ramp_step != 0)
					sh_step = (w.ramp_step > STEP_MAX) ? STEP_MAX : w.ramp_step;
				if (w.interval != 0)
					sh_interval = (w.interval > IVL_MAX) ? IVL_MAX : w.interval;
				sh_target = w.duty;
				sh_ramp = 1'b1;
				sh_countdown = '0;
			end
			OP_READY: begin
				sh_target = sh_ready_duty;
				sh_ramp = 1'b1;
				sh_countdown = '0;
			end
			OP_STANDBY: begin
				sh_target = '0;
				sh_ramp = 1'b1;
				sh_countdown = '0;
			end
			default: ;
		endcase
		r.duty_level = sh_duty;
		r.pwm_compare = compare_of(sh_duty);
		r.pwm_write = wrote;
		r.ramp_running = sh_ramp;
		return r;
	endfunction

	function automatic cmd_word_t word(input logic [OP_W-1:0] op, input int d, input int st,
		input int iv);
		cmd_word_t w;
		w.opcode = op;
		w.duty = d[DUTY_W-1:0];
		w.ramp_step = st[STEP_W-1:0];
		w.interval = iv[IVL_W-1:0];
		return w;
	endfunction

	// Mostly ticks so that ramps run their course, with commands mixed in
	function automatic cmd_word_t random_word();
		int r;
		int st;
		int iv;
		r = $urandom_range(0, 99);
		st = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 64);
		iv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
		if (r < 65) return word(OP_TICK, $urandom_range(0, 255), st, iv);
		if (r < 75) return word(OP_SET, $urandom_range(0, 255), st, iv);
		if (r < 85) return word(OP_RAMP, $urandom_range(0, 255), st, iv);
		if (r < 90) return word(OP_READY, $urandom_range(0, 255), st, iv);
		if (r < 95) return word(OP_STANDBY, $urandom_range(0, 255), st, iv);
		if (r < 97) return word(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
			$urandom_range(0, 255), st, iv);
		return word(OP_W'($urandom_range(0, 7)), $urandom_range(0, 255),
			$urandom_range(0, 127), $urandom_range(0, 63));
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PWM_BITS: sh_pwm_bits = v[BITS_W-1:0];
			REG_READY_DUTY: sh_ready_duty = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (cmd_backlog.size() != 0 || word_offered || duty_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] bits_val,
		input logic [CFG_DATA_W-1:0] ready_val, input int n, input bit flood);
		wait_idle();
		write_reg(REG_PWM_BITS, bits_val);
		write_reg(REG_READY_DUTY, ready_val);
		for (int i = 0; i < n; i++)
			cmd_backlog.push_back(random_word());
		if (flood) begin
			src_calm = 1'b1;
			hold_req = 1'b1;
			while (cmd_backlog.size() != 0) @(posedge clk);
			src_calm = 1'b0;
		end
	endtask

	task automatic report(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Command driver: offer the backlog, hold each word until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				duty_results_due.push_back(advance_duty(word_on_bus));
				word_offered = 1'b0;
				src_gap = src_calm ? 0 : pick_pause();
			end
			if (!word_offered) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (cmd_backlog.size() != 0) begin
					word_on_bus = cmd_backlog.pop_front();
					word_offered = 1'b1;
					cmd_ch.opcode <= word_on_bus.opcode;
					cmd_ch.duty <= word_on_bus.duty;
					cmd_ch.ramp_step <= word_on_bus.ramp_step;
					cmd_ch.interval <= word_on_bus.interval;
				end
			end
			cmd_ch.valid <= word_offered;
		end
	end

	// Result monitor: check each taken word, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (duty_results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual duty %0d", $time,
						res_ch.duty_level);
					errors++;
				end else begin
					res_word_t e;
					e = duty_results_due.pop_front();
					report("duty_level", e.duty_level, res_ch.duty_level);
					report("pwm_compare", e.pwm_compare, res_ch.pwm_compare);
					report("pwm_write", e.pwm_write, res_ch.pwm_write);
					report("ramp_running", e.ramp_running, res_ch.ramp_running);
				end
			end
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy_next = 1'b0;
			end else if (snk_stall > 0) begin
				snk_stall--;
				rdy_next = 1'b0;
			end else begin
				rdy_next = 1'b1;
				if (!snk_calm && $urandom_range(0, 99) < 20) snk_stall = pick_pause();
			end
			res_ch.ready <= rdy_next;
		end
	end

	// Stimulus and end of run
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PWM_BITS;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_TICK;
		cmd_ch.duty = '0;
		cmd_ch.ramp_step = '0;
		cmd_ch.interval = '0;
		res_ch.ready = 1'b0;
		sh_pwm_bits = BITS_RESET;
		sh_ready_duty = READY_RESET;
		sh_duty = '0;
		sh_target = '0;
		sh_step = STEP_RESET;
		sh_interval = IVL_RESET;
		sh_countdown = '0;
		sh_ramp = 1'b0;
		word_offered = 1'b0;
		src_gap = 0;
		snk_stall = 0;
		hold_left = 0;
		hold_req = 1'b0;
		src_calm = 1'b0;
		snk_calm = 1'b0;
		errors = 0;
		cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: same-level set, full swing, ramps both ways, saturation, events
		cmd_backlog.push_back(word(OP_SET, 0, 0, 0));
		cmd_backlog.push_back(word(OP_SET, 255, 0, 0));
		cmd_backlog.push_back(word(OP_SET, 255, 0, 0));
		cmd_backlog.push_back(word(OP_TICK, 0, 0, 0));
		cmd_backlog.push_back(word(OP_RAMP, 0, 127, 1));
		repeat (6) cmd_backlog.push_back(word(OP_TICK, 0, 0, 0));
		cmd_backlog.push_back(word(OP_RAMP, 255, 0, 0));
		cmd_backlog.push_back(word(OP_TICK, 0, 0, 0));
		cmd_backlog.push_back(word(OP_SET, 10, 0, 0));
		cmd_backlog.push_back(word(OP_TICK, 0, 0, 0));
		cmd_backlog.push_back(word(OP_READY, 0, 0, 0));
		cmd_backlog.push_back(word(OP_STANDBY, 0, 0, 0));
		cmd_backlog.push_back(word(OP_SPARE_LO, 255, 127, 63));
		cmd_backlog.push_back(word(OP_SPARE_HI, 255, 127, 63));
		cmd_backlog.push_back(word(OP_RAMP, 74, 3, 63));
		cmd_backlog.push_back(word(OP_TICK, 0, 0, 0));
		cmd_backlog.push_back(word(OP_RAMP, 200, 1, 2));
		repeat (3) cmd_backlog.push_back(word(OP_TICK, 255, 127, 63));

		// Random phases across the resolution and ready-level extremes
		run_phase({3'($urandom_range(0, 7)), 5'd0}, 8'd0, 350, 1'b0);
		run_phase(8'd16, 8'd255, 350, 1'b1);
		snk_calm = 1'b1;
		src_calm = 1'b1;
		run_phase({3'($urandom_range(0, 7)), 5'd31}, 8'($urandom_range(0, 255)), 350, 1'b0);
		wait_idle();
		snk_calm = 1'b0;
		src_calm = 1'b0;
		run_phase(8'd1, 8'($urandom_range(0, 255)), 350, 1'b0);
		run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 600, 1'b0);

		// Drain, then check nothing is left over
		wait_idle();
		if (duty_results_due.size() != 0) begin
			$display("%0t: %0d results missing, expected more, actual none", $time,
				duty_results_due.size());
			errors++;
		end
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
